/* rtl/core/clprm_pkg.sv */
// Shared constants, codes and types for the character list unit.
`default_nettype none

package clprm_pkg;

  // Default list capacity
  localparam int DEPTH_DEF = 32;

  // Fixed field widths
  localparam int ACT_W    = 3;
  localparam int CHAR_W   = 8;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 6;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_PUSH    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_RD_FWD  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_RD_BACK = 3'd3;
  localparam logic [ACT_W-1:0] ACT_CLEAR   = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd3;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_RESP,
    S_REM,
    S_RD
  } state_t;

endpackage

`default_nettype wire

/* rtl/core/clprm_ram.sv */
// Entry store: one write port and one read port with registered read data.
`default_nettype none

module clprm_ram #(
  parameter int DEPTH = clprm_pkg::DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [$clog2(DEPTH)-1:0]      waddr,
  input  wire logic [clprm_pkg::CHAR_W-1:0]  wdata,
  input  wire logic                          re,
  input  wire logic [$clog2(DEPTH)-1:0]      raddr,
  output logic      [clprm_pkg::CHAR_W-1:0]  rdata
);

  logic [clprm_pkg::CHAR_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, hold data when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/char_list_push_front_remove_all_unit.sv */
// Top level: ordered character list with push-front, remove-all, reads and clear.
//
// Usage:
//   Input channel (in_valid/in_stall) carries action and char_in. in_stall is
//   high whenever the sequencer is busy; a new item is taken only when idle.
//   Output channel (out_valid/out_stall) carries status, char_out, count and
//   last; last marks the final result item of each input item.
//   The entries live in a circular buffer in one RAM; a head pointer moves
//   back on push. Push, clear and a read of an empty list give their result
//   through the response state S_RESP. Remove-all walks the list through the
//   single RAM read port and compare, one entry per cycle, then gives its
//   result through S_RESP. Forward and backward reads fetch the first entry
//   from the RAM on acceptance and then give one entry per cycle while
//   out_stall is low. Action codes 5 to 7 are dropped without any result.
//   When out_stall is high the output register holds its item and the
//   sequencer waits; nothing is lost. A result may wait in the output register
//   while the next input item is accepted.
//   Reset (rst, synchronous) empties the list and drops any pending result.
`default_nettype none

module char_list_push_front_remove_all_unit #(
  parameter int DEPTH = clprm_pkg::DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [clprm_pkg::ACT_W-1:0]     action,
  input  wire logic [clprm_pkg::CHAR_W-1:0]    char_in,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [clprm_pkg::STATUS_W-1:0]  status,
  output logic      [clprm_pkg::CHAR_W-1:0]    char_out,
  output logic      [clprm_pkg::COUNT_W-1:0]   count,
  output logic                                 last
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW:0]   DEPTH_A = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] TOP_A   = AW'(DEPTH - 1);

  // Map a list position onto a buffer address
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= DEPTH_A) begin
      s = s - DEPTH_A;
    end
    return s[AW-1:0];
  endfunction

  clprm_pkg::state_t state, state_next;

  logic [AW-1:0]                    head, head_next;
  logic [CW-1:0]                    fill, fill_next;
  logic [CW-1:0]                    idx, idx_next;
  logic [CW-1:0]                    kept, kept_next;
  logic                             pend, pend_next;
  logic [clprm_pkg::ACT_W-1:0]      act_q, act_q_next;
  logic [clprm_pkg::CHAR_W-1:0]     ch_q, ch_q_next;
  logic [clprm_pkg::STATUS_W-1:0]   res_status, res_status_next;

  logic                             out_free;
  logic                             load_out;
  logic [clprm_pkg::STATUS_W-1:0]   ld_status;
  logic [clprm_pkg::CHAR_W-1:0]     ld_char;
  logic                             ld_last;

  logic                             ram_we;
  logic [AW-1:0]                    ram_waddr;
  logic [clprm_pkg::CHAR_W-1:0]     ram_wdata;
  logic                             ram_re;
  logic [AW-1:0]                    ram_raddr;
  logic [clprm_pkg::CHAR_W-1:0]     ram_rdata;

  logic [AW-1:0]                    head_dec;
  logic [CW-1:0]                    nidx;
  logic [CW-1:0]                    npos;
  logic [CW-1:0]                    first_pos;

  clprm_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall = (state != clprm_pkg::S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign head_dec = (head == '0) ? TOP_A : head - 1'b1;
  assign nidx     = idx + 1'b1;
  assign npos     = (act_q == clprm_pkg::ACT_RD_BACK) ? fill - 1'b1 - nidx : nidx;
  assign first_pos = (action == clprm_pkg::ACT_RD_BACK) ? fill - 1'b1 : '0;

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= clprm_pkg::S_IDLE;
      head  <= '0;
      fill  <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      fill  <= fill_next;
      pend  <= pend_next;
    end
  end

  // Hold working registers
  always_ff @(posedge clk) begin
    idx        <= idx_next;
    kept       <= kept_next;
    act_q      <= act_q_next;
    ch_q       <= ch_q_next;
    res_status <= res_status_next;
  end

  // Output register: load a new item or drop the one taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status   <= ld_status;
      char_out <= ld_char;
      count    <= clprm_pkg::COUNT_W'(fill);
      last     <= ld_last;
    end
  end

  // Sequencer: next state, RAM access and result loading
  always_comb begin
    state_next      = state;
    head_next       = head;
    fill_next       = fill;
    idx_next        = idx;
    kept_next       = kept;
    pend_next       = pend;
    act_q_next      = act_q;
    ch_q_next       = ch_q;
    res_status_next = res_status;
    load_out        = 1'b0;
    ld_status       = clprm_pkg::STAT_OK;
    ld_char         = '0;
    ld_last         = 1'b1;
    ram_we          = 1'b0;
    ram_waddr       = '0;
    ram_wdata       = '0;
    ram_re          = 1'b0;
    ram_raddr       = '0;

    case (state)
      clprm_pkg::S_IDLE: begin
        if (in_valid) begin
          case (action)
            clprm_pkg::ACT_PUSH: begin
              if (fill == DEPTH_C) begin
                res_status_next = clprm_pkg::STAT_FULL;
              end else begin
                head_next       = head_dec;
                ram_we          = 1'b1;
                ram_waddr       = head_dec;
                ram_wdata       = char_in;
                fill_next       = fill + 1'b1;
                res_status_next = clprm_pkg::STAT_OK;
              end
              state_next = clprm_pkg::S_RESP;
            end
            clprm_pkg::ACT_REMOVE: begin
              ch_q_next = char_in;
              idx_next  = '0;
              kept_next = '0;
              pend_next = 1'b0;
              if (fill == '0) begin
                res_status_next = clprm_pkg::STAT_NOTFOUND;
                state_next      = clprm_pkg::S_RESP;
              end else begin
                state_next = clprm_pkg::S_REM;
              end
            end
            clprm_pkg::ACT_RD_FWD, clprm_pkg::ACT_RD_BACK: begin
              if (fill == '0) begin
                res_status_next = clprm_pkg::STAT_EMPTY;
                state_next      = clprm_pkg::S_RESP;
              end else begin
                act_q_next = action;
                idx_next   = '0;
                ram_re     = 1'b1;
                ram_raddr  = phys(head, first_pos[AW-1:0]);
                state_next = clprm_pkg::S_RD;
              end
            end
            clprm_pkg::ACT_CLEAR: begin
              fill_next       = '0;
              res_status_next = clprm_pkg::STAT_OK;
              state_next      = clprm_pkg::S_RESP;
            end
            default: begin
            end
          endcase
        end
      end

      // Give the single result of push, remove, clear or an empty read
      clprm_pkg::S_RESP: begin
        if (out_free) begin
          load_out   = 1'b1;
          ld_status  = res_status;
          state_next = clprm_pkg::S_IDLE;
        end
      end

      // Compact the list: keep each entry that differs from the character
      clprm_pkg::S_REM: begin
        if (pend) begin
          if (ram_rdata != ch_q) begin
            ram_we    = 1'b1;
            ram_waddr = phys(head, kept[AW-1:0]);
            ram_wdata = ram_rdata;
            kept_next = kept + 1'b1;
          end
        end
        if (idx < fill) begin
          ram_re    = 1'b1;
          ram_raddr = phys(head, idx[AW-1:0]);
          idx_next  = nidx;
          pend_next = 1'b1;
        end else begin
          pend_next = 1'b0;
        end
        if (!pend && idx == fill) begin
          if (kept == fill) begin
            res_status_next = clprm_pkg::STAT_NOTFOUND;
          end else begin
            fill_next       = kept;
            res_status_next = clprm_pkg::STAT_OK;
          end
          state_next = clprm_pkg::S_RESP;
        end
      end

      // Stream the entries, fetching the next one as each is loaded
      clprm_pkg::S_RD: begin
        if (out_free) begin
          load_out  = 1'b1;
          ld_status = clprm_pkg::STAT_OK;
          ld_char   = ram_rdata;
          ld_last   = (nidx == fill);
          if (nidx == fill) begin
            state_next = clprm_pkg::S_IDLE;
          end else begin
            idx_next  = nidx;
            ram_re    = 1'b1;
            ram_raddr = phys(head, npos[AW-1:0]);
          end
        end
      end

      default: begin
        state_next = clprm_pkg::S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= DEPTH_C)
    else $error("list fill exceeds capacity");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && action == clprm_pkg::ACT_PUSH && fill < DEPTH_C)
    |=> fill == $past(fill) + 1'b1)
    else $error("push did not grow the list by one");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && action == clprm_pkg::ACT_CLEAR) |=> fill == '0)
    else $error("clear left entries in the list");

  a_kept_behind: assert property (@(posedge clk) disable iff (rst)
    (state == clprm_pkg::S_REM) |-> kept <= idx)
    else $error("compaction write overtook the scan");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == clprm_pkg::STAT_EMPTY) |-> (count == '0 && last))
    else $error("empty status with entries or without last");
`endif

endmodule

`default_nettype wire
